// File: hdl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

    // Command codes of the request field command.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register word indexes on the configuration port.
    localparam logic [1:0] REG_TEX_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TEX_HEIGHT = 2'd1;
    localparam logic [1:0] REG_WRAP_MODE  = 2'd2;

    // Coordinate 1.0 in unsigned Q.16.
    localparam logic [16:0] ONE_Q16 = 17'h10000;

    // Largest filtered channel value: 255 with 8 fractional bits.
    localparam logic [15:0] OUT_MAX = 16'hFF00;

    typedef struct packed {
        logic               command;
        logic [7:0]         texel_x;
        logic [7:0]         texel_y;
        logic [7:0]         texel_red;
        logic [7:0]         texel_green;
        logic [7:0]         texel_blue;
        logic [7:0]         texel_alpha;
        logic signed [31:0] coord_u;
        logic signed [31:0] coord_v;
    } in_item_t;

    typedef struct packed {
        logic [15:0] out_red;
        logic [15:0] out_green;
        logic [15:0] out_blue;
        logic [15:0] out_alpha;
    } out_item_t;

endpackage

// File: hdl/bts_blend.sv
// ----------------------------------------------------------------------------
// bts_blend
// Three-stage bilinear blend of four RGBA8 texels: row blend, column blend,
// rounding to 8 fractional bits.
// ----------------------------------------------------------------------------
module bts_blend
    import bts_pkg::*;
#(
    parameter int WF = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [WF-1:0]       s,
    input  logic [WF-1:0]       t,
    input  logic [3:0][7:0]     top_left,
    input  logic [3:0][7:0]     top_right,
    input  logic [3:0][7:0]     bot_left,
    input  logic [3:0][7:0]     bot_right,
    output logic                out_valid,
    output logic [3:0][15:0]    out_chan
);

    localparam int RW    = 8 + WF;
    localparam int ACCW  = 8 + 2 * WF;
    localparam int SHIFT = 2 * WF - 8;
    localparam logic [WF:0] S_ONE = (WF + 1)'(1) << WF;

    logic                   v1_reg, v2_reg, v3_reg;
    logic [WF-1:0]          t1_reg;
    logic [3:0][RW-1:0]     top_reg, bot_reg;
    logic [3:0][ACCW-1:0]   acc_reg;
    logic [3:0][15:0]       out_reg;
    logic [3:0][RW-1:0]     top_next, bot_next;
    logic [3:0][ACCW-1:0]   acc_next;
    logic [3:0][15:0]       out_next;
    logic [WF:0]            s_inv, t_inv;

    always_comb
    begin
        s_inv = S_ONE - {1'b0, s};
        t_inv = S_ONE - {1'b0, t1_reg};
        for (int k = 0; k < 4; k++)
        begin
            top_next[k] = RW'({1'b0, top_left[k]} * s_inv) + RW'(top_right[k] * s);
            bot_next[k] = RW'({1'b0, bot_left[k]} * s_inv) + RW'(bot_right[k] * s);
            acc_next[k] = ACCW'(bot_reg[k] * t_inv) + ACCW'(top_reg[k] * t1_reg);
        end
    end

    generate
        if (SHIFT > 0)
        begin : g_round
            localparam logic [ACCW-1:0] HALF = ACCW'(1) << (SHIFT - 1);
            logic [3:0][ACCW-1:0] rnd;
            always_comb
            begin
                for (int k = 0; k < 4; k++)
                begin
                    rnd[k]      = acc_reg[k] + HALF;
                    out_next[k] = rnd[k][ACCW-1:SHIFT];
                end
            end
        end
        else
        begin : g_exact
            always_comb
            begin
                for (int k = 0; k < 4; k++)
                begin
                    out_next[k] = 16'(acc_reg[k]);
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg  <= t;
        top_reg <= top_next;
        bot_reg <= bot_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    assign out_valid = v3_reg;
    assign out_chan  = out_reg;

endmodule

// File: hdl/bilinear_texture_sampler_core.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core
// Bilinear texture sampler with its own RGBA8 texel store.
// ----------------------------------------------------------------------------
// The block takes one command transaction in every clock cycle; busy is never
// raised. A write command stores one texel and produces no result. A sample
// command produces exactly one result transaction, shown on result for one
// cycle with result_valid high, once it has passed through the pipeline.
// The receiver cannot stall the block. The seven-stage pipeline runs:
// coordinate warp, scale by texture size, corner and weight computation,
// texel store read, row blend, column blend, rounding. The texel store is
// held as four identical banks, one per filter corner, each written by every
// texel write and read at one address per cycle; writes travel down the same
// pipeline so that commands see the store in their issue order. A texel that
// was never written reads back as an arbitrary value. Configuration registers
// (tex_width at 0x0, tex_height at 0x4, wrap_mode at 0x8) may only be written
// while no sample is in flight.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH        = 256,
    parameter int MAX_HEIGHT       = 256,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_item_t    request,
    output logic        result_valid,
    output out_item_t   result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int WF    = WEIGHT_FRAC_BITS;
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] ROW_PITCH = AW'(MAX_WIDTH);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [8:0] tex_width_reg, tex_height_reg;
    logic       wrap_mode_reg;
    logic       cfg_write;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tex_width_reg  <= 9'd256;
            tex_height_reg <= 9'd256;
            wrap_mode_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_TEX_WIDTH:  tex_width_reg  <= pwdata[8:0];
                REG_TEX_HEIGHT: tex_height_reg <= pwdata[8:0];
                REG_WRAP_MODE:  wrap_mode_reg  <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_TEX_WIDTH:  prdata = {23'd0, tex_width_reg};
            REG_TEX_HEIGHT: prdata = {23'd0, tex_height_reg};
            REG_WRAP_MODE:  prdata = {31'd0, wrap_mode_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // Effective texture size: zero acts as one, oversize saturates.
    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;

    always_comb
    begin
        if (tex_width_reg == 9'd0)
            w_eff = WW'(1);
        else if (32'(tex_width_reg) > 32'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(tex_width_reg);

        if (tex_height_reg == 9'd0)
            h_eff = HW'(1);
        else if (32'(tex_height_reg) > 32'(MAX_HEIGHT))
            h_eff = HW'(MAX_HEIGHT);
        else
            h_eff = HW'(tex_height_reg);
    end

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: coordinate warp into [0, 1.0] as unsigned Q.16.
    // ------------------------------------------------------------------
    function automatic logic [16:0] warp(input logic [31:0] c, input logic rep);
        logic [16:0] r;
        if (!c[31] && (c <= 32'(ONE_Q16)))
            r = c[16:0];
        else if (!rep)
            r = c[31] ? 17'd0 : ONE_Q16;
        else
            r = {1'b0, c[15:0]};
        return r;
    endfunction

    logic        smp1_reg, wr1_reg;
    logic [16:0] u1_reg, v1_reg;
    logic [7:0]  wx1_reg, wy1_reg;
    logic [31:0] wd1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp1_reg <= 1'b0;
            wr1_reg  <= 1'b0;
        end
        else
        begin
            smp1_reg <= start && (request.command == CMD_SAMPLE);
            wr1_reg  <= start && (request.command == CMD_WRITE)
                        && (32'(request.texel_x) < 32'(MAX_WIDTH))
                        && (32'(request.texel_y) < 32'(MAX_HEIGHT));
        end
    end

    always_ff @(posedge clk)
    begin
        u1_reg  <= warp(request.coord_u, wrap_mode_reg);
        v1_reg  <= warp(request.coord_v, wrap_mode_reg);
        wx1_reg <= request.texel_x;
        wy1_reg <= request.texel_y;
        wd1_reg <= {request.texel_alpha, request.texel_blue,
                    request.texel_green, request.texel_red};
    end

    // ------------------------------------------------------------------
    // Stage 2: scale by texture size.
    // ------------------------------------------------------------------
    logic               smp2_reg, wr2_reg;
    logic [16+WW-1:0]   su2_reg;
    logic [16+HW-1:0]   sv2_reg;
    logic [7:0]         wx2_reg, wy2_reg;
    logic [31:0]        wd2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp2_reg <= 1'b0;
            wr2_reg  <= 1'b0;
        end
        else
        begin
            smp2_reg <= smp1_reg;
            wr2_reg  <= wr1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        su2_reg <= (16 + WW)'(u1_reg * w_eff);
        sv2_reg <= (16 + HW)'(v1_reg * h_eff);
        wx2_reg <= wx1_reg;
        wy2_reg <= wy1_reg;
        wd2_reg <= wd1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: corner indexes, edge clamp, store addresses and weights.
    // ------------------------------------------------------------------
    logic [WW-1:0] xf, xc, xmax;
    logic [HW-1:0] yf, yc, ymax;
    logic [15:0]   fu, fv, t_full;
    logic [XW-1:0] xfc, xcc;
    logic [YW-1:0] yfc, ycc;
    logic [3:0][AW-1:0] raddr_next;
    logic [AW-1:0] waddr_next;

    always_comb
    begin
        xf   = su2_reg[16 +: WW];
        yf   = sv2_reg[16 +: HW];
        fu   = su2_reg[15:0];
        fv   = sv2_reg[15:0];
        xc   = xf + WW'(fu != 16'd0);
        yc   = yf + HW'(fv != 16'd0);
        xmax = w_eff - WW'(1);
        ymax = h_eff - HW'(1);
        xfc  = XW'((xf > xmax) ? xmax : xf);
        xcc  = XW'((xc > xmax) ? xmax : xc);
        yfc  = YW'((yf > ymax) ? ymax : yf);
        ycc  = YW'((yc > ymax) ? ymax : yc);
        t_full = (fv == 16'd0) ? 16'd0 : 16'(ONE_Q16 - {1'b0, fv});
        // Corner order: top-left, top-right, bottom-left, bottom-right.
        raddr_next[0] = AW'(yfc) * ROW_PITCH + AW'(xfc);
        raddr_next[1] = AW'(yfc) * ROW_PITCH + AW'(xcc);
        raddr_next[2] = AW'(ycc) * ROW_PITCH + AW'(xfc);
        raddr_next[3] = AW'(ycc) * ROW_PITCH + AW'(xcc);
        waddr_next    = AW'(wy2_reg) * ROW_PITCH + AW'(wx2_reg);
    end

    logic               smp3_reg, wr3_reg;
    logic [3:0][AW-1:0] raddr3_reg;
    logic [AW-1:0]      waddr3_reg;
    logic [31:0]        wd3_reg;
    logic [WF-1:0]      s3_reg, t3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp3_reg <= 1'b0;
            wr3_reg  <= 1'b0;
        end
        else
        begin
            smp3_reg <= smp2_reg;
            wr3_reg  <= wr2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        raddr3_reg <= raddr_next;
        waddr3_reg <= waddr_next;
        wd3_reg    <= wd2_reg;
        s3_reg     <= fu[15 -: WF];
        t3_reg     <= t_full[15 -: WF];
    end

    // ------------------------------------------------------------------
    // Stage 4: texel store, one bank per corner, registered read.
    // ------------------------------------------------------------------
    logic [3:0][31:0] rdata4_reg;
    logic             smp4_reg;
    logic [WF-1:0]    s4_reg, t4_reg;

    generate
        for (genvar b = 0; b < 4; b++)
        begin : g_bank
            logic [31:0] mem [DEPTH];

            always_ff @(posedge clk)
            begin
                if (wr3_reg)
                begin
                    mem[waddr3_reg] <= wd3_reg;
                end
                rdata4_reg[b] <= mem[raddr3_reg[b]];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            smp4_reg <= 1'b0;
        else
            smp4_reg <= smp3_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_reg <= s3_reg;
        t4_reg <= t3_reg;
    end

    // ------------------------------------------------------------------
    // Stages 5 to 7: blend and round.
    // ------------------------------------------------------------------
    logic [3:0][15:0] chan;

    bts_blend #(
        .WF (WF)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp4_reg),
        .s         (s4_reg),
        .t         (t4_reg),
        .top_left  (rdata4_reg[0]),
        .top_right (rdata4_reg[1]),
        .bot_left  (rdata4_reg[2]),
        .bot_right (rdata4_reg[3]),
        .out_valid (result_valid),
        .out_chan  (chan)
    );

    assign result.out_red   = chan[0];
    assign result.out_green = chan[1];
    assign result.out_blue  = chan[2];
    assign result.out_alpha = chan[3];

`ifndef SYNTHESIS
    // Every result stems from a sample command that entered the pipeline.
    a_result_from_sample: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && (request.command == CMD_SAMPLE), 7))
        else $error("result without matching sample command");

    // A blend of 8-bit texels never exceeds 255.0.
    a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.out_red <= OUT_MAX) && (result.out_green <= OUT_MAX)
                      && (result.out_blue <= OUT_MAX) && (result.out_alpha <= OUT_MAX))
        else $error("filtered channel out of range");

    // A write command never yields a result.
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start && (request.command == CMD_WRITE), 7) |-> !result_valid)
        else $error("result after write command");
`endif

endmodule

// File: sim/bilinear_texture_sampler_core_tb.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_core_tb
// Self-checking testbench for the bilinear texture sampler core.
// ----------------------------------------------------------------------------
// Before every sample the four texels it will read are written if they have
// not been written yet, so no sample can ever touch an unwritten texel. A
// short directed part covers coordinate extremes, both wrap modes and writes
// at the store corners. After that, random phases run under several texture
// sizes, including out-of-range register values. A scoreboard predicts every
// filtered result and checks each result transaction against the oldest
// prediction.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_core_tb;
    import bts_pkg::*;

    localparam int STORE_SIDE  = 256;
    localparam int WATCH_LIMIT = 2000;
    localparam int SETTLE      = 12;
    localparam int IN_BITS     = $bits(in_item_t);

    // Predicts filtered colors from its own copy of the store and registers.
    class filter_scoreboard;
        bit [31:0]   texels [STORE_SIDE*STORE_SIDE];
        int unsigned width_reg  = 256;
        int unsigned height_reg = 256;
        bit          repeat_mode = 0;
        out_item_t   expected_colors [$];
        int          mismatches = 0;

        function int unsigned clamp_size(int unsigned value);
            if (value == 0)
                return 1;
            if (value > STORE_SIDE)
                return STORE_SIDE;
            return value;
        endfunction

        // Brings a Q15.16 coordinate into [0, 1.0] as unsigned Q.16.
        function int unsigned warp(logic [31:0] c);
            if (!c[31] && c <= 32'h10000)
                return c;
            if (!repeat_mode)
                return c[31] ? 0 : 32'h10000;
            return c[15:0];
        endfunction

        function bit [31:0] texel_at(int unsigned x, int unsigned y,
                                     int unsigned w, int unsigned h);
            if (x > w - 1)
                x = w - 1;
            if (y > h - 1)
                y = h - 1;
            return texels[y*STORE_SIDE + x];
        endfunction

        // Store index of corner k of a sample: bit 0 selects the right
        // column, bit 1 the bottom row.
        function int unsigned corner_index(logic [31:0] u, logic [31:0] v, int k);
            int unsigned w, h, su, sv, xf, yf, xc, yc, x, y;
            w  = clamp_size(width_reg);
            h  = clamp_size(height_reg);
            su = warp(u) * w;
            sv = warp(v) * h;
            xf = su >> 16;
            yf = sv >> 16;
            xc = xf + ((su & 16'hFFFF) != 0);
            yc = yf + ((sv & 16'hFFFF) != 0);
            x  = k[0] ? xc : xf;
            y  = k[1] ? yc : yf;
            if (x > w - 1)
                x = w - 1;
            if (y > h - 1)
                y = h - 1;
            return y*STORE_SIDE + x;
        endfunction

        function out_item_t filter(logic [31:0] u, logic [31:0] v);
            int unsigned w, h, su, sv, xf, yf, xc, yc, fu, fv, s, t;
            bit [31:0]   b0, b1, t0, t1;
            longint      bot, top, acc;
            logic [15:0] chans [4];
            out_item_t   res;
            w  = clamp_size(width_reg);
            h  = clamp_size(height_reg);
            su = warp(u) * w;
            sv = warp(v) * h;
            xf = su >> 16;
            fu = su & 16'hFFFF;
            yf = sv >> 16;
            fv = sv & 16'hFFFF;
            xc = xf + (fu != 0);
            yc = yf + (fv != 0);
            s  = fu >> 8;
            t  = ((fv == 0) ? 0 : (32'h10000 - fv)) >> 8;
            b0 = texel_at(xf, yc, w, h);
            b1 = texel_at(xc, yc, w, h);
            t0 = texel_at(xf, yf, w, h);
            t1 = texel_at(xc, yf, w, h);
            for (int k = 0; k < 4; k++)
            begin
                bot = longint'(b0[8*k +: 8]) * (256 - s) + longint'(b1[8*k +: 8]) * s;
                top = longint'(t0[8*k +: 8]) * (256 - s) + longint'(t1[8*k +: 8]) * s;
                acc = bot * (256 - t) + top * t;
                acc = (acc + 128) >> 8;
                chans[k] = acc[15:0];
            end
            res.out_red   = chans[0];
            res.out_green = chans[1];
            res.out_blue  = chans[2];
            res.out_alpha = chans[3];
            return res;
        endfunction

        function void note_request(in_item_t r);
            if (r.command == CMD_WRITE)
                texels[{r.texel_y, r.texel_x}] =
                    {r.texel_alpha, r.texel_blue, r.texel_green, r.texel_red};
            else
                expected_colors.push_back(filter(r.coord_u, r.coord_v));
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected_colors.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transaction %h", got);
                return;
            end
            want = expected_colors.pop_front();
            if (got.out_red !== want.out_red || got.out_green !== want.out_green ||
                got.out_blue !== want.out_blue || got.out_alpha !== want.out_alpha)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Color mismatch: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                             want.out_red, want.out_green, want.out_blue, want.out_alpha,
                             got.out_red, got.out_green, got.out_blue, got.out_alpha);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        start = 0;
    logic        busy;
    in_item_t    request = '0;
    logic        result_valid;
    out_item_t   result;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    filter_scoreboard colors = new();
    int          idle_cycles_since = 0;
    bit          gaps_enabled = 0;
    int unsigned phase_width = 256;
    int          items_sent = 0;
    // Texels that a command already sent will have written.
    bit          loaded [STORE_SIDE*STORE_SIDE];

    always #10 clk = ~clk;

    bilinear_texture_sampler_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Both monitors run off the pre-edge values, so they see exactly what the
    // block sampled. A write and a later sample are predicted in issue order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                colors.note_request(request);
            if (result_valid)
                colors.check_result(result);
        end
    end

    // The watchdog counts cycles in which no transaction of any kind happens.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || psel)
            idle_cycles_since <= 0;
        else
            idle_cycles_since <= idle_cycles_since + 1;
        if (idle_cycles_since >= WATCH_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offers one command and holds it until the block takes it. start is left
    // high afterwards; the next call either replaces the command or idles.
    task automatic send_command(in_item_t item);
        start   <= 1'b1;
        request <= item;
        items_sent++;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Random bursts of idle cycles ahead of a command.
    task automatic maybe_idle();
        if (gaps_enabled && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (colors.expected_colors.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Setup and access cycle of one register write; the caller closes the
    // transfer after the last write.
    task automatic write_register(logic [1:0] index, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (index)
            REG_TEX_WIDTH:  colors.width_reg  = 32'(value[8:0]);
            REG_TEX_HEIGHT: colors.height_reg = 32'(value[8:0]);
            REG_WRAP_MODE:  colors.repeat_mode = value[0];
            default: ;
        endcase
    endtask

    task automatic configure(int unsigned w, int unsigned h, bit wrap);
        wait_drained();
        write_register(REG_TEX_WIDTH, w);
        write_register(REG_TEX_HEIGHT, h);
        write_register(REG_WRAP_MODE, 32'(wrap));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        phase_width = colors.clamp_size(w);
    endtask

    // Every field carries random bits so that unused fields toggle as well.
    function automatic in_item_t random_item();
        in_item_t it;
        it = IN_BITS'({$urandom, $urandom, $urandom, $urandom});
        return it;
    endfunction

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 32'h10000);
            1:       return $urandom;
            2:       return -$urandom_range(1, 200000);
            3:       return 32'h10000 + $urandom_range(1, 200000);
            4:       return ($urandom_range(0, phase_width) * 32'h10000) / phase_width;
            default: return $urandom_range(0, 3) == 0 ? 32'h10000 : $urandom_range(0, 16);
        endcase
    endfunction

    task automatic write_texel(logic [7:0] x, logic [7:0] y, logic [31:0] rgba);
        in_item_t it;
        it = random_item();
        it.command = CMD_WRITE;
        it.texel_x = x;
        it.texel_y = y;
        {it.texel_alpha, it.texel_blue, it.texel_green, it.texel_red} = rgba;
        loaded[{y, x}] = 1'b1;
        send_command(it);
    endtask

    // Writes any corner texel that is still unwritten, then samples.
    task automatic sample_at(logic [31:0] u, logic [31:0] v);
        in_item_t    it;
        int unsigned idx;
        for (int k = 0; k < 4; k++)
        begin
            idx = colors.corner_index(u, v, k);
            if (!loaded[idx])
                write_texel(idx[7:0], idx[15:8], $urandom);
        end
        it = random_item();
        it.command = CMD_SAMPLE;
        it.coord_u = u;
        it.coord_v = v;
        send_command(it);
    endtask

    // Sends commands until count more have gone out, corner writes included.
    task automatic random_phase(int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            maybe_idle();
            if ($urandom_range(0, 9) < 3)
                write_texel(8'($urandom), 8'($urandom), $urandom);
            else
                sample_at(random_coord(), random_coord());
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coordinate extremes under the reset size, clamp mode.
        write_texel(8'd0, 8'd0, 32'h00000000);
        write_texel(8'd255, 8'd255, 32'hFFFFFFFF);
        write_texel(8'd255, 8'd0, 32'hFF00FF00);
        sample_at(32'h00000000, 32'h00000000);
        sample_at(32'h00010000, 32'h00010000);
        sample_at(32'h7FFFFFFF, 32'h80000000);
        sample_at(32'hFFFFFFFF, 32'h00010001);
        sample_at(32'h00008000, 32'h00008080);
        sample_at(32'h0000FFFF, 32'h00000001);
        sample_at(32'h00010000, 32'h00000000);
        // Repeat mode, including negative coordinates and their fractions.
        configure(256, 256, 1'b1);
        sample_at(32'hFFFFFFFF, 32'hFFFF8000);
        sample_at(32'h80000000, 32'h7FFFFFFF);
        sample_at(32'h00018000, 32'hFFFE4000);
        sample_at(32'h00010000, 32'h00010000);
        // Sizes outside the register range act as the nearest legal size.
        configure(0, 0, 1'b0);
        sample_at(32'h00008000, 32'h00010000);
        configure(511, 257, 1'b0);
        sample_at(32'h00010000, 32'h0000C000);
        sample_at(32'h00004000, 32'hFFFF0000);
        configure(1, 256, 1'b1);
        sample_at(32'h12345678, 32'h0000FF80);

        gaps_enabled = 1;
        configure(2, 3, 1'b1);
        random_phase(130);
        configure(256, 256, 1'b0);
        random_phase(65);
        // Hold off the sender until every outstanding sample has returned.
        wait_drained();
        random_phase(65);
        configure(1, 1, 1'b0);
        random_phase(130);
        configure(7, 5, 1'b1);
        random_phase(130);
        configure(0, 256, 1'b1);
        random_phase(130);
        configure(300, 1, 1'b0);
        random_phase(130);
        for (int p = 0; p < 4; p++)
        begin
            configure($urandom_range(0, 511), $urandom_range(0, 511),
                      1'($urandom_range(0, 1)));
            random_phase(130);
        end
        configure(256, 256, 1'b1);
        random_phase(130);
        gaps_enabled = 0;
        configure($urandom_range(1, 32), $urandom_range(1, 32), 1'b1);
        random_phase(130);

        wait_drained();
        if (colors.mismatches == 0 && colors.expected_colors.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// File: bilinear_texture_sampler_core.f
hdl/bts_pkg.sv
hdl/bts_blend.sv
hdl/bilinear_texture_sampler_core.sv
sim/bilinear_texture_sampler_core_tb.sv
